[design/cfse_pkg.sv]
package cfse_pkg;

  // Line buffer geometry
  localparam int MAX_COLUMN_CELLS = 256;
  localparam int ROW_W            = $clog2(MAX_COLUMN_CELLS);
  localparam int ROWS_CAP_I       = (MAX_COLUMN_CELLS - 2) < 254 ? (MAX_COLUMN_CELLS - 2) : 254;

  // Field widths
  localparam int CODE_W     = 8;
  localparam int FLAG_W     = 9;
  localparam int COL_W      = 13;
  localparam int OUT_ROW_W  = 8;
  localparam int COUNT_W    = 21;
  localparam int CFG_COLS_W = 12;
  localparam int CFG_ROWS_W = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_BITS    = FLAG_W + COL_W + OUT_ROW_W + 1 + 1 + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 12'd62;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 8'd62;
  localparam logic [CFG_ROWS_W-1:0] ROWS_CAP   = CFG_ROWS_W'(ROWS_CAP_I);

  // Geometry codes
  localparam logic [CODE_W-1:0] CODE_NOSLIP   = 8'd0;
  localparam logic [CODE_W-1:0] CODE_FREESLIP = 8'd1;
  localparam logic [CODE_W-1:0] CODE_OUTFLOW  = 8'd2;
  localparam logic [CODE_W-1:0] CODE_INFLOW   = 8'd3;
  localparam logic [CODE_W-1:0] CODE_COUPLING = 8'd4;
  localparam logic [CODE_W-1:0] CODE_FLUID    = 8'd6;

  // Flag bit positions
  localparam int FB_FLUID    = 0;
  localparam int FB_NOSLIP   = 1;
  localparam int FB_FREESLIP = 2;
  localparam int FB_OUTFLOW  = 3;
  localparam int FB_INFLOW   = 4;
  localparam int FB_N        = 5;
  localparam int FB_S        = 6;
  localparam int FB_W        = 7;
  localparam int FB_E        = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_idx_t;

  // Which result of an item is being sent
  typedef enum logic [1:0] {
    PH_WEST,
    PH_BELOW,
    PH_SELF
  } phase_t;

  // Line buffer request, one per accepted cell
  typedef struct packed {
    logic              en;
    logic              col_end;
    logic [ROW_W-1:0]  row;
    logic [CODE_W-1:0] code;
  } lb_req_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flag;
    logic              forbid;
  } cell_flag_t;

  // Class bits, neighbor bits and the forbidden test for one cell
  function automatic cell_flag_t encode_cell(input logic [CODE_W-1:0] code,
                                             input logic nf, input logic sf,
                                             input logic wf, input logic ef);
    cell_flag_t res;
    logic       open_cell;
    res.flag = '0;
    case (code)
      CODE_NOSLIP:   res.flag[FB_NOSLIP]   = 1'b1;
      CODE_FREESLIP: res.flag[FB_FREESLIP] = 1'b1;
      CODE_OUTFLOW:  res.flag[FB_OUTFLOW]  = 1'b1;
      CODE_INFLOW:   res.flag[FB_INFLOW]   = 1'b1;
      CODE_FLUID:    res.flag[FB_FLUID]    = 1'b1;
      default:       res.flag              = '0;
    endcase
    open_cell = (code == CODE_OUTFLOW) || (code == CODE_INFLOW) || (code == CODE_FLUID);
    if (!open_cell) begin
      res.flag[FB_N] = nf;
      res.flag[FB_S] = sf;
      res.flag[FB_W] = wf;
      res.flag[FB_E] = ef;
    end
    res.forbid = (code != CODE_FLUID) && ((wf && ef) || (nf && sf));
    return res;
  endfunction

endpackage

[design/cfse_line_buf.sv]
// Two column buffers used ping-pong: one holds the previous column, the
// other the column before it and takes the current column as it streams in.
module cfse_line_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfse_pkg::lb_req_t       req,
  output logic [cfse_pkg::CODE_W-1:0] prev_next,   // previous column, row + 1
  output logic [cfse_pkg::CODE_W-1:0] older_here   // column before that, same row
);
  import cfse_pkg::*;

  logic [CODE_W-1:0] mem_a [MAX_COLUMN_CELLS];
  logic [CODE_W-1:0] mem_b [MAX_COLUMN_CELLS];
  logic [CODE_W-1:0] rd_a_r;
  logic [CODE_W-1:0] rd_b_r;
  logic              bank_r;
  logic              sel_r;
  logic [ROW_W-1:0]  row_up;
  logic [ROW_W-1:0]  addr_a;
  logic [ROW_W-1:0]  addr_b;

  // bank_r low: A is the older column, B the previous column
  assign row_up = req.row + ROW_W'(1);
  assign addr_a = bank_r ? row_up : req.row;
  assign addr_b = bank_r ? req.row : row_up;

  // Swap roles at every column end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (req.en && req.col_end) begin
      bank_r <= ~bank_r;
    end
  end

  // Read-first memories: the older entry is read before it is overwritten
  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_a_r <= mem_a[addr_a];
      if (!bank_r) begin
        mem_a[req.row] <= req.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_b_r <= mem_b[addr_b];
      if (bank_r) begin
        mem_b[req.row] <= req.code;
      end
    end
  end

  // Bank as it was when the read was issued
  always_ff @(posedge clk) begin
    if (req.en) begin
      sel_r <= bank_r;
    end
  end

  assign older_here = sel_r ? rd_b_r : rd_a_r;
  assign prev_next  = sel_r ? rd_a_r : rd_b_r;

endmodule

[design/cell_flag_stencil_encoder.sv]
// Channel  Direction  Payload (from bit 0 up)
// in_      slave      tdata: cell_code[7:0]
// out_     master     tdata: flag_word, cell_column, cell_row, cell_forbidden,
//                            any_forbidden, coupling_count, 3 zero bits; tlast: frame_last
// cfg_     write      cfg_addr 0 interior_columns, 1 interior_rows
//
// One cell per cycle while the output is not stalled, at most one result each,
// outside the last column; there a cell below row 0 gives two results (the final
// cell three), one per cycle. Each result passes the result stage and then the
// output register; the column buffers are read at the accepting edge (one read
// port each). Reset is synchronous; every buffer entry that a result uses is
// written first. An output stall holds the result register and backs up to in_tready.
module cell_flag_stencil_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cfse_pkg::IN_TDATA_W-1:0]      in_tdata,   // cell_code[7:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // flag_word[8:0], cell_column[21:9], cell_row[29:22], cell_forbidden[30],
  // any_forbidden[31], coupling_count[52:32], zero[55:53]
  output logic [cfse_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,  // frame_last
  input  logic                                 cfg_we,
  input  logic [cfse_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [cfse_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cfse_pkg::*;

  // Configuration
  logic [CFG_COLS_W-1:0] cols_r;
  logic [CFG_ROWS_W-1:0] rows_r;
  logic [CFG_COLS_W-1:0] cols_eff;
  logic [CFG_ROWS_W-1:0] rows_eff;
  logic [COL_W-1:0]      last_col;
  logic [ROW_W-1:0]      last_row;
  logic                  cfg_hit;

  // Accept side position
  logic [COL_W-1:0]  col_pos_r;
  logic [ROW_W-1:0]  row_pos_r;
  logic              in_acc;
  logic              col_end;
  lb_req_t           lb_req;
  logic [CODE_W-1:0] prev_next;
  logic [CODE_W-1:0] older_here;

  // Result stage
  logic              s_valid_r;
  logic [CODE_W-1:0] s_code_r;
  logic [COL_W-1:0]  s_col_r;
  logic [ROW_W-1:0]  s_row_r;
  phase_t            phase_r;
  phase_t            phase_nxt;
  phase_t            final_phase;
  logic [CODE_W-1:0] win_pc_r;
  logic [CODE_W-1:0] win_pm_r;
  logic [CODE_W-1:0] row0_r;
  logic [CODE_W-1:0] cur0_r;
  logic [CODE_W-1:0] cur1_r;
  logic [CODE_W-1:0] pc;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic              err_r;
  logic              err_nxt;
  logic              has_res;
  logic              at_last_col;
  logic              out_free;
  logic              emit;
  logic              retire;
  logic              emit_last;

  // Selected result
  logic [CODE_W-1:0] e_code;
  logic [COL_W-1:0]  e_col;
  logic [ROW_W-1:0]  e_row;
  logic              e_nf, e_sf, e_wf, e_ef;
  cell_flag_t        e_flag;

  // Output register
  logic                   out_valid_r;
  logic [OUT_BITS-1:0]    out_data_r;
  logic                   out_last_r;

  // Effective geometry
  assign cols_eff = (cols_r == '0) ? CFG_COLS_W'(1) : cols_r;
  always_comb begin
    rows_eff = rows_r;
    if (rows_r == '0) begin
      rows_eff = CFG_ROWS_W'(1);
    end else if (rows_r > ROWS_CAP) begin
      rows_eff = ROWS_CAP;
    end
  end
  assign last_col = COL_W'(cols_eff) + COL_W'(1);
  assign last_row = ROW_W'(rows_eff) + ROW_W'(1);

  // Configuration writes restart the frame
  assign cfg_hit = cfg_we && ((cfg_addr == CFG_COLUMNS) || (cfg_addr == CFG_ROWS));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_COLUMNS) begin
        cols_r <= cfg_wdata[CFG_COLS_W-1:0];
      end else begin
        rows_r <= cfg_wdata[CFG_ROWS_W-1:0];
      end
    end
  end

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s_valid_r || retire;
  assign in_acc    = in_tvalid && in_tready;
  assign col_end   = (row_pos_r == last_row);

  // Scan position of the next cell
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        row_pos_r <= '0;
        col_pos_r <= (col_pos_r >= last_col) ? '0 : col_pos_r + COL_W'(1);
      end else begin
        row_pos_r <= row_pos_r + ROW_W'(1);
      end
    end
  end

  assign lb_req.en      = in_acc;
  assign lb_req.col_end = col_end;
  assign lb_req.row     = row_pos_r;
  assign lb_req.code    = in_tdata[CODE_W-1:0];

  cfse_line_buf u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (lb_req),
    .prev_next  (prev_next),
    .older_here (older_here)
  );

  // Result stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_code_r <= in_tdata[CODE_W-1:0];
      s_col_r  <= col_pos_r;
      s_row_r  <= row_pos_r;
    end
  end

  // Result list of the held cell
  assign pc          = (s_row_r == '0) ? row0_r : win_pc_r;
  assign has_res     = (s_col_r != '0);
  assign at_last_col = (s_col_r == last_col);

  always_comb begin
    if (at_last_col && (s_row_r == last_row)) begin
      final_phase = PH_SELF;
    end else if (at_last_col && (s_row_r != '0)) begin
      final_phase = PH_BELOW;
    end else begin
      final_phase = PH_WEST;
    end
  end

  assign emit      = s_valid_r && has_res && out_free;
  assign retire    = s_valid_r && (!has_res || (out_free && (phase_r == final_phase)));
  assign emit_last = emit && (phase_r == PH_SELF);

  // Sequencer: next phase and the selected result
  always_comb begin
    phase_nxt = phase_r;
    if (retire) begin
      phase_nxt = PH_WEST;
    end else if (emit) begin
      case (phase_r)
        PH_WEST:  phase_nxt = PH_BELOW;
        PH_BELOW: phase_nxt = PH_SELF;
        default:  phase_nxt = PH_WEST;
      endcase
    end

    case (phase_r)
      PH_BELOW: begin
        e_code = cur0_r;
        e_col  = s_col_r;
        e_row  = s_row_r - ROW_W'(1);
        e_nf   = (s_code_r == CODE_FLUID);
        e_sf   = (s_row_r > ROW_W'(1)) && (cur1_r == CODE_FLUID);
        e_wf   = (win_pm_r == CODE_FLUID);
        e_ef   = 1'b0;
      end
      PH_SELF: begin
        e_code = s_code_r;
        e_col  = s_col_r;
        e_row  = s_row_r;
        e_nf   = 1'b0;
        e_sf   = (cur0_r == CODE_FLUID);
        e_wf   = (pc == CODE_FLUID);
        e_ef   = 1'b0;
      end
      default: begin
        e_code = pc;
        e_col  = s_col_r - COL_W'(1);
        e_row  = s_row_r;
        e_nf   = (s_row_r != last_row) && (prev_next == CODE_FLUID);
        e_sf   = (s_row_r != '0) && (win_pm_r == CODE_FLUID);
        e_wf   = (s_col_r > COL_W'(1)) && (older_here == CODE_FLUID);
        e_ef   = (s_code_r == CODE_FLUID);
      end
    endcase
  end

  assign e_flag  = encode_cell(e_code, e_nf, e_sf, e_wf, e_ef);
  assign cnt_nxt = cnt_r + COUNT_W'(e_code == CODE_COUPLING);
  assign err_nxt = err_r | e_flag.forbid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WEST;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Frame statistics, cleared after the final result and on restart
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      cnt_r <= '0;
      err_r <= 1'b0;
    end else if (emit_last) begin
      cnt_r <= '0;
      err_r <= 1'b0;
    end else if (emit) begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  // Neighbor window, advanced when the held cell is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur0_r <= '0;
      cur1_r <= '0;
    end else if (retire) begin
      cur1_r <= cur0_r;
      cur0_r <= s_code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      win_pc_r <= prev_next;
      win_pm_r <= pc;
      if (s_row_r == '0) begin
        row0_r <= s_code_r;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {cnt_nxt, err_nxt, e_flag.forbid, e_row, e_col, e_flag.flag};
      out_last_r <= (phase_r == PH_SELF);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

[design/cfse_checker.sv]
module cfse_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cfse_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);
  import cfse_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Sticky error covers the current forbidden cell
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FLAG_W+COL_W+OUT_ROW_W] |-> out_tdata[FLAG_W+COL_W+OUT_ROW_W+1])
    else $error("forbidden cell without sticky error");

  // At most one class bit
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[FB_INFLOW:FB_FLUID]))
    else $error("several class bits set");

  // Fluid cells carry no neighbor bits and are never forbidden
  a_fluid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FB_FLUID] |->
      (out_tdata[FB_E:FB_N] == '0) && !out_tdata[FLAG_W+COL_W+OUT_ROW_W])
    else $error("fluid cell with neighbor or forbidden bits");

endmodule

bind cell_flag_stencil_encoder cfse_checker u_cfse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[sim/tb_top.sv]
module tb_top;
  import cfse_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  // Settle time before a register write; column 0 cells leave no result behind
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CODE_W-1:0] CODE_UNUSED = 8'd5;

  // One expected flag result
  typedef struct packed {
    logic [FLAG_W-1:0]    flag;
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] row;
    logic                 forbid;
    logic                 any_forbid;
    logic [COUNT_W-1:0]   coupling;
    logic                 last;
  } cell_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  cell_flag_stencil_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Stimulus and expectation stores
  logic [CODE_W-1:0] codes_to_send [$];
  cell_result_t      flag_words_due [$];
  int                mismatches = 0;
  int                cycles = 0;

  // Shadow of the encoder state
  logic [CFG_COLS_W-1:0] cols_reg = COLS_RESET;
  logic [CFG_ROWS_W-1:0] rows_reg = ROWS_RESET;
  logic [CODE_W-1:0]     col_bank [0:511];  // two column buffers, swapped by older_sel
  logic                  older_sel = 1'b0;
  logic [CODE_W-1:0]     recent0 = '0;
  logic [CODE_W-1:0]     recent1 = '0;
  int                    col_pos = 0;
  int                    row_pos = 0;
  logic [COUNT_W-1:0]    coupling_total = '0;
  logic                  forbid_seen = 1'b0;

  function automatic logic is_fluid(input logic [CODE_W-1:0] code);
    return code == CODE_FLUID;
  endfunction

  function automatic logic [CODE_W-1:0] prev_code(input int idx);
    return col_bank[{~older_sel, idx[7:0]}];
  endfunction

  function automatic void clear_frame();
    col_pos        = 0;
    row_pos        = 0;
    coupling_total = '0;
    forbid_seen    = 1'b0;
  endfunction

  // Build one flag word from a cell and its neighbor fluid bits
  function automatic void emit_flag(input int col, input int row,
                                    input logic [CODE_W-1:0] code,
                                    input logic nf, input logic sf,
                                    input logic wf, input logic ef,
                                    input logic last);
    cell_result_t res;
    res = '0;
    case (code)
      CODE_NOSLIP:   res.flag[FB_NOSLIP]   = 1'b1;
      CODE_FREESLIP: res.flag[FB_FREESLIP] = 1'b1;
      CODE_OUTFLOW:  res.flag[FB_OUTFLOW]  = 1'b1;
      CODE_INFLOW:   res.flag[FB_INFLOW]   = 1'b1;
      CODE_FLUID:    res.flag[FB_FLUID]    = 1'b1;
      default:       res.flag              = '0;
    endcase
    if (code == CODE_COUPLING) coupling_total = coupling_total + 1'b1;
    // open cells carry no neighbor bits
    if (code != CODE_OUTFLOW && code != CODE_INFLOW && code != CODE_FLUID) begin
      res.flag[FB_N] = nf;
      res.flag[FB_S] = sf;
      res.flag[FB_W] = wf;
      res.flag[FB_E] = ef;
    end
    res.forbid     = (code != CODE_FLUID) && ((wf && ef) || (nf && sf));
    forbid_seen    = forbid_seen | res.forbid;
    res.col        = COL_W'(col);
    res.row        = OUT_ROW_W'(row);
    res.any_forbid = forbid_seen;
    res.coupling   = coupling_total;
    res.last       = last;
    flag_words_due.push_back(res);
  endfunction

  // Advance the shadow state by one accepted cell
  function automatic void predict_cell_flags(input logic [CODE_W-1:0] code);
    int cols, rows, last_col, last_row, c, r;
    cols = (cols_reg == 0) ? 1 : int'(cols_reg);
    rows = (rows_reg == 0) ? 1 : int'(rows_reg);
    if (rows > ROWS_CAP) rows = ROWS_CAP;
    last_col = cols + 1;
    last_row = rows + 1;
    c = col_pos;
    r = row_pos;

    // west cell of the same row
    if (c > 0)
      emit_flag(c - 1, r, prev_code(r),
                (r < last_row) && is_fluid(prev_code(r + 1)),
                (r > 0) && is_fluid(prev_code(r - 1)),
                (c > 1) && is_fluid(col_bank[{older_sel, r[7:0]}]),
                is_fluid(code), 1'b0);
    // last column: the cell below, and the final cell itself
    if (c == last_col) begin
      if (r > 0)
        emit_flag(c, r - 1, recent0, is_fluid(code),
                  (r > 1) && is_fluid(recent1),
                  is_fluid(prev_code(r - 1)), 1'b0, 1'b0);
      if (r == last_row)
        emit_flag(c, r, code, 1'b0, is_fluid(recent0),
                  is_fluid(prev_code(r)), 1'b0, 1'b1);
    end

    col_bank[{older_sel, r[7:0]}] = code;
    recent1 = recent0;
    recent0 = code;
    if (r >= last_row) begin
      older_sel = ~older_sel;
      row_pos   = 0;
      if (c >= last_col) clear_frame();
      else col_pos = c + 1;
    end else begin
      row_pos = r + 1;
    end
  endfunction

  // Sender: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_cells
    logic              next_valid;
    logic [CODE_W-1:0] next_code;
    next_valid = in_tvalid;
    next_code  = in_tdata;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_cell_flags(in_tdata);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (codes_to_send.size() > 0) begin
          next_valid = 1'b1;
          next_code  = codes_to_send.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_code;
  end

  // Receiver: windows of always-ready, random stalls, or a rotating mask
  int         ready_window = 0;
  int         ready_mode = 0;
  logic [7:0] ready_mask = 8'hff;

  always @(posedge clk) begin : drive_ready
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      if (ready_window == 0) begin
        ready_mode   = $urandom_range(0, 2);
        ready_window = $urandom_range(20, 120);
        ready_mask   = 8'($urandom) | 8'h01;
      end
      ready_window--;
      case (ready_mode)
        0:       next_ready = 1'b1;
        1:       next_ready = ($urandom_range(0, 3) != 0);
        default: begin
          ready_mask = {ready_mask[6:0], ready_mask[7]};
          next_ready = ready_mask[0];
        end
      endcase
    end
    out_tready <= next_ready;
  end

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_flags
    cell_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.flag       = out_tdata[8:0];
      got.col        = out_tdata[21:9];
      got.row        = out_tdata[29:22];
      got.forbid     = out_tdata[30];
      got.any_forbid = out_tdata[31];
      got.coupling   = out_tdata[52:32];
      got.last       = out_tlast;
      if (flag_words_due.size() == 0) begin
        $display("%0t unexpected result: expected none, got column %0d row %0d",
                 $time, got.col, got.row);
        mismatches++;
      end else begin
        want = flag_words_due.pop_front();
        check_field("flag_word", want.flag, got.flag);
        check_field("cell_column", want.col, got.col);
        check_field("cell_row", want.row, got.row);
        check_field("cell_forbidden", want.forbid, got.forbid);
        check_field("any_forbidden", want.any_forbid, got.any_forbid);
        check_field("coupling_count", want.coupling, got.coupling);
        check_field("frame_last", want.last, got.last);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Wait until every request is sent and every result has come back
  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (codes_to_send.size() != 0 || in_tvalid || flag_words_due.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Register write; only called while the encoder is idle
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLUMNS) cols_reg = value;
    else rows_reg = value[CFG_ROWS_W-1:0];
    clear_frame();
    @(negedge clk);
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return CODE_FLUID;
    if (sel < 8) return CODE_W'($urandom_range(0, 4));
    if (sel == 8) return $urandom_range(0, 1) ? CODE_UNUSED : CODE_W'(7);
    return CODE_W'($urandom_range(0, 255));
  endfunction

  // Queue a frame of random cells, optionally pausing midway until drained
  task automatic send_cells(input int count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_idle(0);
      codes_to_send.push_back(pick_code());
    end
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] frame_a [9];
    logic [CODE_W-1:0] frame_b [9];
    int cols, rows, total, sent, count, pause_at;
    bit broken, first;

    // 3x3 frames: center forbidden both ways, every class, coupling and unknown codes
    frame_a = '{CODE_NOSLIP, CODE_FLUID, CODE_FREESLIP,
                CODE_FLUID, CODE_NOSLIP, CODE_FLUID,
                CODE_OUTFLOW, CODE_FLUID, CODE_COUPLING};
    frame_b = '{CODE_INFLOW, CODE_FLUID, 8'hff,
                CODE_FLUID, CODE_COUPLING, CODE_FLUID,
                CODE_UNUSED, CODE_FLUID, CODE_FLUID};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // smallest frame, two in a row to cross the frame end
    write_reg(CFG_COLUMNS, 12'd1);
    write_reg(CFG_ROWS, 12'd1);
    foreach (frame_a[i]) codes_to_send.push_back(frame_a[i]);
    foreach (frame_b[i]) codes_to_send.push_back(frame_b[i]);

    // partial frame cut short by a register write
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_COLUMNS, 12'd2);
    send_cells(5, -1);
    wait_idle(SETTLE_CYCLES);

    // widest frame, zero rows acting as one; only its first columns are sent
    write_reg(CFG_ROWS, 12'hf00);
    write_reg(CFG_COLUMNS, 12'd4095);
    send_cells(12, -1);
    wait_idle(SETTLE_CYCLES);

    // tallest column, rows above the cap and zero columns, then a few more cells
    write_reg(CFG_COLUMNS, 12'd0);
    write_reg(CFG_ROWS, 12'h3ff);
    send_cells(256 + 14, -1);

    // random frames, mostly whole, some broken off
    sent   = 0;
    broken = 1'b0;
    first  = 1'b1;
    while (sent < 100) begin
      if (broken || first || $urandom_range(0, 2) != 0) begin
        cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
        wait_idle(SETTLE_CYCLES);
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
          write_reg(CFG_ROWS, {4'($urandom), 8'(rows)});
        end else begin
          write_reg(CFG_ROWS, {4'($urandom), 8'(rows)});
          write_reg(CFG_COLUMNS, CFG_DATA_W'(cols));
        end
      end
      total  = ((cols_reg == 0 ? 1 : cols_reg) + 2) *
               ((rows_reg == 0 ? 1 : (rows_reg > ROWS_CAP ? ROWS_CAP : rows_reg)) + 2);
      broken = ($urandom_range(0, 4) == 0);
      count  = broken ? $urandom_range(1, total - 1) : total;
      pause_at = (first || $urandom_range(0, 3) == 0) ? count / 2 : -1;
      send_cells(count, pause_at);
      sent  += count;
      first  = 1'b0;
    end

    wait_idle(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
